// ----- rtl/xdrt_pkg.sv -----
// Shared types, constants and codes for the XOR distance routing table.
// Used by xdrt_msb and xor_distance_routing_table; depends on nothing.
package xdrt_pkg;

  localparam int BUCKETS        = 64;
  localparam int BUCKET_W       = 6;
  localparam int ID_W           = 64;
  localparam int ADDR_W         = 32;
  localparam int PORT_W         = 16;
  localparam int COUNT_W        = 10;
  localparam int BUCKET_CAP_DEF = 8;
  localparam int MAX_TOTAL_DEF  = 512;

  typedef enum logic [1:0] {
    MODE_TOUCH   = 2'd0,
    MODE_REMOVE  = 2'd1,
    MODE_CLOSEST = 2'd2,
    MODE_NEAREST = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_MOVED     = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_ENTRY     = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_MSB,
    S_FILL_RD,
    S_FILL_USE,
    S_FIND_RD,
    S_FIND_CMP,
    S_MISS,
    S_SHIFT_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_HEAD_WR,
    S_RESULT,
    S_SC_FILL_RD,
    S_SC_FILL_USE,
    S_SC_RD,
    S_SC_CMP,
    S_PASS_END,
    S_EM_RD,
    S_EM_OUT
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef struct packed {
    logic                done;
    logic [BUCKET_W-1:0] idx;
  } msb_stat_t;

endpackage

// ----- rtl/xor_distance_routing_table.sv -----
// Top level of the XOR distance routing table: sequencer, entry store and bucket fill store.
// Depends on xdrt_pkg and xdrt_msb.
//
// One word is taken at a time; in_ready_o is high only while the block is idle. Touch and
// remove run a highest-bit search of id XOR local_id, read the bucket fill, then compare
// the stored entries in turn and shift entries to make room or close the gap. A closest
// search runs up to BUCKET_CAP passes over the table, each pass reading every bucket fill
// and every stored entry, then reports the chosen words one at a time. A nearest lookup is
// one such pass followed by a touch of the nearest entry, or a local result if no entry is
// nearer than the local id. The entry memory has a registered read. The bucket fill store
// is cleared by per-bucket valid bits, so no clearing pass follows reset.
module xor_distance_routing_table
  import xdrt_pkg::*;
#(
  parameter int BUCKET_CAP = BUCKET_CAP_DEF,
  parameter int MAX_TOTAL  = MAX_TOTAL_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               local_id_we_i,
  input  logic [ID_W-1:0]    local_id_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [ID_W-1:0]    node_id_i,
  input  logic [ADDR_W-1:0]  node_addr_i,
  input  logic [PORT_W-1:0]  node_port_i,
  input  logic [ID_W-1:0]    target_key_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic               entry_valid_o,
  output logic [ID_W-1:0]    entry_id_o,
  output logic [ADDR_W-1:0]  entry_addr_o,
  output logic [PORT_W-1:0]  entry_port_o,
  output logic               is_local_o,
  output logic [COUNT_W-1:0] total_count_o,
  output logic               last_o
);

  localparam int Slots = BUCKETS * BUCKET_CAP;
  localparam int SlotW = $clog2(Slots);
  localparam int FillW = $clog2(BUCKET_CAP + 1);
  localparam int PosW  = (BUCKET_CAP > 1) ? $clog2(BUCKET_CAP) : 1;
  localparam int TotW  = $clog2(MAX_TOTAL + 1);
  localparam logic [FillW-1:0]    CapF   = FillW'(BUCKET_CAP);
  localparam logic [TotW-1:0]     MaxTot = TotW'(MAX_TOTAL);
  localparam logic [BUCKET_W-1:0] LastB  = BUCKET_W'(BUCKETS - 1);

  state_e              state_q, state_d;
  logic [ID_W-1:0]     local_q;
  mode_e               mode_q, mode_d;
  logic [ID_W-1:0]     op_id_q, op_id_d;
  logic [ADDR_W-1:0]   op_addr_q, op_addr_d;
  logic [PORT_W-1:0]   op_port_q, op_port_d;
  logic [ID_W-1:0]     key_q, key_d;
  logic [BUCKET_W-1:0] b_q, b_d;
  logic [FillW-1:0]    n_q, n_d;
  logic [FillW-1:0]    j_q, j_d;
  logic                found_q, found_d;
  logic [ID_W-1:0]     best_d_q, best_d_d;
  logic [SlotW-1:0]    best_s_q, best_s_d;
  logic                got_q, got_d;
  logic                have_prev_q, have_prev_d;
  logic [ID_W-1:0]     prev_d_q, prev_d_d;
  logic [SlotW-1:0]    prev_s_q, prev_s_d;
  logic [FillW-1:0]    cnt_q, cnt_d;
  logic [FillW-1:0]    k_q, k_d;
  logic [SlotW-1:0]    chosen_q [BUCKET_CAP];
  logic                remote_q, remote_d;
  status_e             res_status_q, res_status_d;
  logic                res_ent_q, res_ent_d;
  logic                res_local_q, res_local_d;
  logic [TotW-1:0]     total_q, total_d;

  logic                out_vld_q, out_vld_d;
  status_e             out_status_q, out_status_d;
  logic                out_ent_q, out_ent_d;
  logic [ID_W-1:0]     out_id_q, out_id_d;
  logic [ADDR_W-1:0]   out_addr_q, out_addr_d;
  logic [PORT_W-1:0]   out_port_q, out_port_d;
  logic                out_local_q, out_local_d;
  logic [TotW-1:0]     out_total_q, out_total_d;
  logic                out_last_q, out_last_d;

  entry_t              ent_mem_q [Slots];
  entry_t              rd_q;
  logic [SlotW-1:0]    mem_ra;
  logic                mem_we;
  entry_t              mem_wd;
  logic [FillW-1:0]    fill_mem_q [BUCKETS];
  logic [BUCKETS-1:0]  fill_vld_q;
  logic [FillW-1:0]    fill_rd_q;
  logic                fill_rv_q;
  logic                fill_we;
  logic [FillW-1:0]    fill_wd;
  logic [FillW-1:0]    fill_val;

  logic                accept;
  logic                out_free;
  logic                is_remove;
  logic                shift_more;
  logic                chosen_we;
  logic [FillW-1:0]    j_p1, j_m1, cnt_p1, k_p1;
  logic [SlotW-1:0]    slot_cur, slot_p1, slot_m1;
  logic [ID_W-1:0]     key_dist;
  logic                skip, take;
  logic                msb_start;
  msb_stat_t           msb_stat;

  function automatic logic [SlotW-1:0] slot_of(logic [BUCKET_W-1:0] b, logic [FillW-1:0] j);
    slot_of = SlotW'(int'(b) * BUCKET_CAP) + SlotW'(j);
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_vld_q || out_ready_i;
  assign is_remove  = (mode_q == MODE_REMOVE);
  assign j_p1       = j_q + 1'b1;
  assign j_m1       = j_q - 1'b1;
  assign cnt_p1     = cnt_q + 1'b1;
  assign k_p1       = k_q + 1'b1;
  assign slot_cur   = slot_of(b_q, j_q);
  assign slot_p1    = slot_of(b_q, j_p1);
  assign slot_m1    = slot_of(b_q, j_m1);
  assign fill_val   = fill_rv_q ? fill_rd_q : '0;
  assign shift_more = is_remove ? (j_p1 < n_q) : (j_q != '0);
  assign key_dist   = rd_q.id ^ key_q;
  assign skip       = have_prev_q &&
                      ((key_dist < prev_d_q) ||
                       ((key_dist == prev_d_q) && (slot_cur <= prev_s_q)));
  assign take       = (mode_q == MODE_CLOSEST) ? (!skip && (!got_q || key_dist < best_d_q))
                                               : (key_dist < best_d_q);

  xdrt_msb u_msb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (msb_start),
    .value_i (op_id_q ^ local_q),
    .stat_o  (msb_stat)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        case (mode_q)
          MODE_TOUCH, MODE_REMOVE: state_d = (op_id_q == local_q) ? S_RESULT : S_MSB;
          default:                 state_d = S_SC_FILL_RD;
        endcase
      end
      S_MSB: begin
        if (msb_stat.done) state_d = S_FILL_RD;
      end
      S_FILL_RD:  state_d = S_FILL_USE;
      S_FILL_USE: state_d = (fill_val == '0) ? S_MISS : S_FIND_RD;
      S_FIND_RD:  state_d = S_FIND_CMP;
      S_FIND_CMP: begin
        if (rd_q.id == op_id_q) state_d = S_SHIFT_CHK;
        else if (j_p1 == n_q)   state_d = S_MISS;
        else                    state_d = S_FIND_RD;
      end
      S_MISS: state_d = is_remove ? S_RESULT : S_SHIFT_CHK;
      S_SHIFT_CHK: begin
        if (shift_more)     state_d = S_SHIFT_RD;
        else if (is_remove) state_d = S_RESULT;
        else                state_d = S_HEAD_WR;
      end
      S_SHIFT_RD: state_d = S_SHIFT_WR;
      S_SHIFT_WR: state_d = S_SHIFT_CHK;
      S_HEAD_WR:  state_d = S_RESULT;
      S_RESULT: begin
        if (out_free) state_d = S_IDLE;
      end
      S_SC_FILL_RD: state_d = S_SC_FILL_USE;
      S_SC_FILL_USE: begin
        if (fill_val != '0)  state_d = S_SC_RD;
        else if (b_q == LastB) state_d = S_PASS_END;
        else                 state_d = S_SC_FILL_RD;
      end
      S_SC_RD: state_d = S_SC_CMP;
      S_SC_CMP: begin
        if (j_p1 != n_q)       state_d = S_SC_RD;
        else if (b_q == LastB) state_d = S_PASS_END;
        else                   state_d = S_SC_FILL_RD;
      end
      S_PASS_END: begin
        if (mode_q == MODE_CLOSEST) begin
          if (got_q)           state_d = (cnt_p1 == CapF) ? S_EM_RD : S_SC_FILL_RD;
          else if (cnt_q == '0) state_d = S_RESULT;
          else                 state_d = S_EM_RD;
        end else begin
          state_d = remote_q ? S_MSB : S_RESULT;
        end
      end
      S_EM_RD: state_d = S_EM_OUT;
      S_EM_OUT: begin
        if (out_free) state_d = (k_p1 == cnt_q) ? S_IDLE : S_EM_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mode_d       = mode_q;
    op_id_d      = op_id_q;
    op_addr_d    = op_addr_q;
    op_port_d    = op_port_q;
    key_d        = key_q;
    b_d          = b_q;
    n_d          = n_q;
    j_d          = j_q;
    found_d      = found_q;
    best_d_d     = best_d_q;
    best_s_d     = best_s_q;
    got_d        = got_q;
    have_prev_d  = have_prev_q;
    prev_d_d     = prev_d_q;
    prev_s_d     = prev_s_q;
    cnt_d        = cnt_q;
    k_d          = k_q;
    remote_d     = remote_q;
    res_status_d = res_status_q;
    res_ent_d    = res_ent_q;
    res_local_d  = res_local_q;
    total_d      = total_q;
    out_vld_d    = out_vld_q && !out_ready_i;
    out_status_d = out_status_q;
    out_ent_d    = out_ent_q;
    out_id_d     = out_id_q;
    out_addr_d   = out_addr_q;
    out_port_d   = out_port_q;
    out_local_d  = out_local_q;
    out_total_d  = out_total_q;
    out_last_d   = out_last_q;
    mem_ra       = slot_cur;
    mem_we       = 1'b0;
    mem_wd       = rd_q;
    fill_we      = 1'b0;
    fill_wd      = n_q;
    chosen_we    = 1'b0;
    msb_start    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d    = mode_e'(mode_i);
          op_id_d   = (mode_e'(mode_i) == MODE_REMOVE) ? target_key_i : node_id_i;
          op_addr_d = node_addr_i;
          op_port_d = node_port_i;
          key_d     = target_key_i;
        end
      end
      S_START: begin
        res_status_d = (mode_q == MODE_TOUCH) ? ST_IGNORED : ST_NOT_FOUND;
        res_ent_d    = 1'b0;
        res_local_d  = 1'b0;
        b_d          = '0;
        got_d        = 1'b0;
        have_prev_d  = 1'b0;
        cnt_d        = '0;
        remote_d     = 1'b0;
        best_d_d     = local_q ^ key_q;
        msb_start    = (mode_q == MODE_TOUCH || mode_q == MODE_REMOVE) &&
                       (op_id_q != local_q);
      end
      S_MSB: begin
        if (msb_stat.done) b_d = msb_stat.idx;
      end
      S_FILL_USE, S_SC_FILL_USE: begin
        n_d = fill_val;
        j_d = '0;
        if (state_q == S_SC_FILL_USE && fill_val == '0) b_d = b_q + 1'b1;
      end
      S_FIND_CMP: begin
        if (rd_q.id == op_id_q) found_d = 1'b1;
        else                    j_d     = j_p1;
      end
      S_MISS: begin
        found_d      = 1'b0;
        res_status_d = ST_NOT_FOUND;
        if (!is_remove) begin
          if (total_q < MaxTot) total_d = total_q + 1'b1;
          if (n_q < CapF) begin
            j_d     = n_q;
            fill_we = 1'b1;
            fill_wd = n_q + 1'b1;
          end else begin
            j_d = CapF - 1'b1;
          end
        end
      end
      S_SHIFT_CHK: begin
        if (!shift_more && is_remove) begin
          fill_we      = 1'b1;
          fill_wd      = n_q - 1'b1;
          res_status_d = ST_REMOVED;
          if (total_q != '0) total_d = total_q - 1'b1;
        end
      end
      S_SHIFT_RD: begin
        mem_ra = is_remove ? slot_p1 : slot_m1;
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1;
        j_d    = is_remove ? j_p1 : j_m1;
      end
      S_HEAD_WR: begin
        mem_we = 1'b1;
        mem_wd = '{id: op_id_q, addr: op_addr_q, port: op_port_q};
        if (mode_q == MODE_NEAREST) begin
          res_status_d = ST_ENTRY;
          res_ent_d    = 1'b1;
        end else begin
          res_status_d = found_q ? ST_MOVED : ST_INSERTED;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_ent_d    = res_ent_q;
          out_id_d     = res_ent_q ? op_id_q : '0;
          out_addr_d   = res_ent_q ? op_addr_q : '0;
          out_port_d   = res_ent_q ? op_port_q : '0;
          out_local_d  = res_local_q;
          out_total_d  = total_q;
          out_last_d   = 1'b1;
        end
      end
      S_SC_CMP: begin
        if (take) begin
          got_d    = 1'b1;
          remote_d = 1'b1;
          best_d_d = key_dist;
          best_s_d = slot_cur;
          if (mode_q == MODE_NEAREST) begin
            op_id_d   = rd_q.id;
            op_addr_d = rd_q.addr;
            op_port_d = rd_q.port;
          end
        end
        j_d = j_p1;
        if (j_p1 == n_q) b_d = b_q + 1'b1;
      end
      S_PASS_END: begin
        b_d   = '0;
        got_d = 1'b0;
        k_d   = '0;
        if (mode_q == MODE_CLOSEST) begin
          if (got_q) begin
            chosen_we   = 1'b1;
            cnt_d       = cnt_p1;
            have_prev_d = 1'b1;
            prev_d_d    = best_d_q;
            prev_s_d    = best_s_q;
          end
        end else begin
          msb_start = remote_q;
          if (!remote_q) begin
            res_status_d = ST_ENTRY;
            res_local_d  = 1'b1;
          end
        end
      end
      S_EM_RD: begin
        mem_ra = chosen_q[k_q[PosW-1:0]];
      end
      S_EM_OUT: begin
        mem_ra = chosen_q[k_q[PosW-1:0]];
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_status_d = ST_ENTRY;
          out_ent_d    = 1'b1;
          out_id_d     = rd_q.id;
          out_addr_d   = rd_q.addr;
          out_port_d   = rd_q.port;
          out_local_d  = 1'b0;
          out_total_d  = total_q;
          out_last_d   = (k_p1 == cnt_q);
          k_d          = k_p1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      local_q    <= '0;
      total_q    <= '0;
      out_vld_q  <= 1'b0;
      fill_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      out_vld_q <= out_vld_d;
      if (local_id_we_i) local_q <= local_id_i;
      if (fill_we) fill_vld_q[b_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    op_id_q      <= op_id_d;
    op_addr_q    <= op_addr_d;
    op_port_q    <= op_port_d;
    key_q        <= key_d;
    b_q          <= b_d;
    n_q          <= n_d;
    j_q          <= j_d;
    found_q      <= found_d;
    best_d_q     <= best_d_d;
    best_s_q     <= best_s_d;
    got_q        <= got_d;
    have_prev_q  <= have_prev_d;
    prev_d_q     <= prev_d_d;
    prev_s_q     <= prev_s_d;
    cnt_q        <= cnt_d;
    k_q          <= k_d;
    remote_q     <= remote_d;
    res_status_q <= res_status_d;
    res_ent_q    <= res_ent_d;
    res_local_q  <= res_local_d;
    out_status_q <= out_status_d;
    out_ent_q    <= out_ent_d;
    out_id_q     <= out_id_d;
    out_addr_q   <= out_addr_d;
    out_port_q   <= out_port_d;
    out_local_q  <= out_local_d;
    out_total_q  <= out_total_d;
    out_last_q   <= out_last_d;
    if (chosen_we) chosen_q[cnt_q[PosW-1:0]] <= best_s_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) ent_mem_q[slot_cur] <= mem_wd;
    rd_q <= ent_mem_q[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem_q[b_q] <= fill_wd;
    fill_rd_q <= fill_mem_q[b_q];
    fill_rv_q <= fill_vld_q[b_q];
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_status_q;
  assign entry_valid_o = out_ent_q;
  assign entry_id_o    = out_id_q;
  assign entry_addr_o  = out_addr_q;
  assign entry_port_o  = out_port_q;
  assign is_local_o    = out_local_q;
  assign total_count_o = COUNT_W'(out_total_q);
  assign last_o        = out_last_q;

  // The saturating count never passes its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni) total_q <= MaxTot)
    else $error("entry count above limit");

  // A bucket never reports more entries than it can hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL_USE || state_q == S_SC_FILL_USE) |-> fill_val <= CapF)
    else $error("bucket fill above capacity");

  // Compares during a scan stay inside the filled part of the bucket.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SC_CMP || state_q == S_FIND_CMP) |-> j_q < n_q)
    else $error("scan position beyond bucket fill");

  // A closest search never collects more words than a bucket holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EM_OUT) |-> (cnt_q <= CapF && k_q < cnt_q))
    else $error("closest list index out of range");

endmodule

// ----- rtl/xdrt_msb.sv -----
// Iterative search for the highest set bit of a 64-bit word, one bit per cycle.
// Depends on xdrt_pkg.
module xdrt_msb
  import xdrt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ID_W-1:0] value_i,
  output msb_stat_t       stat_o
);

  logic                busy_q, busy_d;
  logic [ID_W-1:0]     val_q, val_d;
  logic [BUCKET_W-1:0] idx_q, idx_d;
  logic                hit;

  assign hit = val_q[ID_W-1] || (idx_q == '0);

  always_comb begin
    busy_d = busy_q;
    val_d  = val_q;
    idx_d  = idx_q;
    if (start_i) begin
      busy_d = 1'b1;
      val_d  = value_i;
      idx_d  = '1;
    end else if (busy_q) begin
      if (hit) begin
        busy_d = 1'b0;
      end else begin
        val_d = val_q << 1;
        idx_d = idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    idx_q <= idx_d;
  end

  assign stat_o.done = busy_q && hit;
  assign stat_o.idx  = idx_q;

endmodule
